>>> rtl/tlzd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlzd_pkg
// Shared types and constants for the texture token LZ decoder.
// ----------------------------------------------------------------------------
package tlzd_pkg;

	localparam int TABLE_ENTRIES = 2048;
	localparam int TBL_AW        = 11;
	localparam int MAX_RUN       = 31;
	localparam int S_TDATA_W     = 48;
	localparam int M_TDATA_W     = 40;

	// item commands
	localparam logic [1:0] CMD_DECODE  = 2'd0;
	localparam logic [1:0] CMD_TABLE   = 2'd1;
	localparam logic [1:0] CMD_RESTART = 2'd2;

	// format modes
	localparam logic [2:0] MODE_RAW      = 3'd0;
	localparam logic [2:0] MODE_RGBA16   = 3'd1;
	localparam logic [2:0] MODE_RGBA32   = 3'd2;
	localparam logic [2:0] MODE_IA8      = 3'd3;
	localparam logic [2:0] MODE_IA16_TBL = 3'd4;
	localparam logic [2:0] MODE_RGBA_TBL = 3'd5;
	localparam logic [2:0] MODE_IA8_SIX  = 3'd6;
	localparam logic [2:0] MODE_RAW_ALT  = 3'd7;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_LOOKUP,
		ST_LIT_WR,
		ST_EMIT_LIT,
		ST_EMIT_ERR,
		ST_COPY_RD,
		ST_COPY,
		ST_EMIT_CPY
	} state_t;

	typedef struct packed {
		logic load;
		logic table_wr;
		logic restart;
		logic lit_latch;
		logic lit_wr;
		logic copy_first;
		logic copy_wr;
		logic out_lit;
		logic out_err;
		logic out_cpy;
	} ctl_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic       is_raw;
		logic       is_ref;
		logic       bad_dist;
		logic       count_zero;
		logic       byte_last;
		logic       run_last;
		logic       out_free;
	} stat_t;

endpackage
`default_nettype wire

>>> rtl/tlzd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlzd_ctrl
// Sequencer: steps each request through decode, then table write, restart, literal write, error result or unit copy.
// ----------------------------------------------------------------------------
module tlzd_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           s_tvalid,
	output logic                s_tready,
	input  tlzd_pkg::stat_t     st,
	output tlzd_pkg::ctl_t      ctl
);

	tlzd_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tlzd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		ctl      = '0;
		s_tready = 1'b0;
		case (state_q)
			tlzd_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					ctl.load = 1'b1;
					state_d  = tlzd_pkg::ST_DECODE;
				end
			end
			tlzd_pkg::ST_DECODE: begin
				state_d = tlzd_pkg::ST_IDLE;
				case (st.cmd)
					tlzd_pkg::CMD_TABLE:   ctl.table_wr = 1'b1;
					tlzd_pkg::CMD_RESTART: ctl.restart = 1'b1;
					tlzd_pkg::CMD_DECODE: begin
						if (!st.is_ref)         state_d = tlzd_pkg::ST_LOOKUP;
						else if (st.bad_dist)   state_d = tlzd_pkg::ST_EMIT_ERR;
						else if (!st.count_zero) state_d = tlzd_pkg::ST_COPY_RD;
					end
					default: state_d = tlzd_pkg::ST_IDLE;
				endcase
			end
			tlzd_pkg::ST_LOOKUP: begin
				ctl.lit_latch = 1'b1;
				state_d       = tlzd_pkg::ST_LIT_WR;
			end
			tlzd_pkg::ST_LIT_WR: begin
				ctl.lit_wr = 1'b1;
				if (st.byte_last) state_d = tlzd_pkg::ST_EMIT_LIT;
			end
			tlzd_pkg::ST_EMIT_LIT: begin
				if (st.out_free) begin
					ctl.out_lit = 1'b1;
					state_d     = tlzd_pkg::ST_IDLE;
				end
			end
			tlzd_pkg::ST_EMIT_ERR: begin
				if (st.out_free) begin
					ctl.out_err = 1'b1;
					state_d     = tlzd_pkg::ST_IDLE;
				end
			end
			tlzd_pkg::ST_COPY_RD: begin
				ctl.copy_first = 1'b1;
				state_d        = tlzd_pkg::ST_COPY;
			end
			tlzd_pkg::ST_COPY: begin
				ctl.copy_wr = 1'b1;
				if (st.byte_last) state_d = tlzd_pkg::ST_EMIT_CPY;
			end
			tlzd_pkg::ST_EMIT_CPY: begin
				if (st.out_free) begin
					ctl.out_cpy = 1'b1;
					state_d     = st.run_last ? tlzd_pkg::ST_IDLE : tlzd_pkg::ST_COPY_RD;
				end
			end
			default: state_d = tlzd_pkg::ST_IDLE;
		endcase
	end

endmodule
`default_nettype wire

>>> rtl/tlzd_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlzd_dp
// Datapath: format register, history and table memories, unit assembly.
// ----------------------------------------------------------------------------
module tlzd_dp #(
	parameter int HISTORY_BYTES = 2048
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  tlzd_pkg::ctl_t                      ctl,
	output tlzd_pkg::stat_t                     st,
	input  wire logic [tlzd_pkg::S_TDATA_W-1:0] s_tdata,
	input  wire logic [1:0]                     s_tuser,
	input  wire logic                           cfg_valid,
	input  wire logic [2:0]                     cfg_data,
	input  wire logic                           m_tready,
	output logic                                m_tvalid,
	output logic [tlzd_pkg::M_TDATA_W-1:0]      m_tdata,
	output logic                                m_tlast,
	output logic [0:0]                          m_tuser
);

	localparam int AW = $clog2(HISTORY_BYTES);
	localparam logic [AW-1:0] WP_MAX = AW'(HISTORY_BYTES - 1);

	logic [2:0]  fmt_q;
	logic [1:0]  cmd_q;
	logic [15:0] token_q;
	logic [tlzd_pkg::TBL_AW-1:0] idx_q;
	logic [15:0] val_q;

	logic [AW-1:0] wp_q, src_q, src_calc, rd_addr, wp_next, src_next;
	logic [AW:0]   diff;
	logic          full_q;
	logic [7:0]    hist_mem [HISTORY_BYTES];
	logic [7:0]    hist_rd_q, rbyte, lbyte, wbyte;
	logic          hist_ok_q;

	logic [15:0] tbl_mem [tlzd_pkg::TABLE_ENTRIES];
	logic [15:0] tbl_a_q, tbl_b_q;
	logic [tlzd_pkg::TBL_AW-1:0] tbl_addr_a, tbl_addr_b;

	logic [31:0] data_q, lit_val;
	logic [1:0]  byte_q, lsel;
	logic [4:0]  remain_q;
	logic        unit4, is_raw, wr_en;
	logic [10:0] back_dist;
	logic        out_vld_q, out_free;

	// config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= tlzd_pkg::MODE_RAW;
		end else if (cfg_valid) begin
			fmt_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q   <= s_tuser;
			token_q <= s_tdata[15:0];
			idx_q   <= s_tdata[26:16];
			val_q   <= s_tdata[42:27];
		end
	end

	assign is_raw = (fmt_q == tlzd_pkg::MODE_RAW) || (fmt_q == tlzd_pkg::MODE_RAW_ALT);
	assign unit4  = (fmt_q == tlzd_pkg::MODE_RGBA32) || (fmt_q == tlzd_pkg::MODE_IA16_TBL) ||
	                (fmt_q == tlzd_pkg::MODE_RGBA_TBL);
	assign back_dist = unit4 ? {token_q[14:5], 1'b0} : {1'b0, token_q[14:5]};

	// history addressing; reads before the first written byte give zero
	assign diff     = {1'b0, wp_q} - (AW+1)'(back_dist);
	assign src_calc = diff[AW] ? AW'(diff + (AW+1)'(HISTORY_BYTES)) : diff[AW-1:0];
	assign rd_addr  = ctl.copy_first ? src_calc : src_q;
	assign src_next = (rd_addr == WP_MAX) ? '0 : rd_addr + 1'b1;
	assign wp_next  = (wp_q == WP_MAX) ? '0 : wp_q + 1'b1;

	always_ff @(posedge clk) begin
		src_q     <= src_next;
		hist_rd_q <= hist_mem[rd_addr];
		hist_ok_q <= full_q || (rd_addr < wp_q);
		if (wr_en) hist_mem[wp_q] <= wbyte;
	end

	assign rbyte = hist_ok_q ? hist_rd_q : 8'h00;
	assign lsel  = unit4 ? (2'd3 - byte_q) : (2'd1 - byte_q);
	assign lbyte = data_q[lsel*8 +: 8];
	assign wr_en = ctl.lit_wr | ctl.copy_wr;
	assign wbyte = ctl.lit_wr ? lbyte : rbyte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			full_q <= 1'b0;
		end else if (ctl.restart) begin
			wp_q   <= '0;
			full_q <= 1'b0;
		end else if (wr_en) begin
			wp_q <= wp_next;
			if (wp_q == WP_MAX) full_q <= 1'b1;
		end
	end

	// expansion table: one write port, two read ports
	assign tbl_addr_a = (fmt_q == tlzd_pkg::MODE_RGBA_TBL) ? token_q[14:4]
	                                                       : {4'b0, token_q[15:9]};
	assign tbl_addr_b = {4'b0, token_q[7:1]};

	always_ff @(posedge clk) begin
		if (ctl.table_wr) tbl_mem[idx_q] <= val_q;
		tbl_a_q <= tbl_mem[tbl_addr_a];
		tbl_b_q <= tbl_mem[tbl_addr_b];
	end

	function automatic logic [7:0] six_bit(input logic [7:0] b);
		six_bit = {b[5:3], 1'b0, b[2:0], 1'b0};
	endfunction

	always_comb begin
		lit_val = '0;
		if (is_raw) begin
			lit_val = {16'h0, token_q};
		end else begin
			case (fmt_q)
				tlzd_pkg::MODE_RGBA16:
					lit_val = {15'h0, token_q[15:6], 1'b0, token_q[5:0]};
				tlzd_pkg::MODE_RGBA32:
					lit_val = {token_q[14:11], 4'h0, token_q[10:7], 4'h0,
					           token_q[6:3], 4'h0, token_q[2:0], 5'h0};
				tlzd_pkg::MODE_IA8:
					lit_val = {16'h0, token_q[14:8], 1'b0, token_q[6:0], 1'b0};
				tlzd_pkg::MODE_IA16_TBL:
					lit_val = {tbl_a_q[14:0], token_q[8], tbl_b_q[14:0], token_q[0]};
				tlzd_pkg::MODE_RGBA_TBL:
					lit_val = {tbl_a_q[14:10], 3'h0, tbl_a_q[9:5], 3'h0,
					           tbl_a_q[4:0], 3'h0, token_q[3:0], 4'h0};
				default:
					lit_val = {16'h0, six_bit(token_q[15:8]), six_bit(token_q[7:0])};
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.lit_latch)       data_q <= lit_val;
		else if (ctl.copy_first) data_q <= '0;
		else if (ctl.copy_wr)    data_q <= {data_q[23:0], rbyte};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q   <= '0;
			remain_q <= '0;
		end else begin
			if (ctl.lit_latch || ctl.copy_first) byte_q <= '0;
			else if (wr_en)                      byte_q <= byte_q + 1'b1;
			if (ctl.load)         remain_q <= s_tdata[4:0];
			else if (ctl.out_cpy) remain_q <= remain_q - 1'b1;
		end
	end

	// result register
	assign out_free = !out_vld_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (ctl.out_lit || ctl.out_err || ctl.out_cpy) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_err) begin
			m_tdata <= '0;
			m_tlast <= 1'b1;
			m_tuser <= 1'b1;
		end else if (ctl.out_lit || ctl.out_cpy) begin
			m_tdata <= {5'h0, (unit4 ? 3'd4 : 3'd2), data_q};
			m_tlast <= ctl.out_lit ? 1'b1 : (remain_q == 5'd1);
			m_tuser <= 1'b0;
		end
	end

	assign m_tvalid = out_vld_q;

	assign st.cmd        = cmd_q;
	assign st.is_raw     = is_raw;
	assign st.is_ref     = token_q[15] && !is_raw;
	assign st.bad_dist   = unit4 ? (back_dist < 11'd4) : (back_dist < 11'd2);
	assign st.count_zero = (token_q[4:0] == 5'd0);
	assign st.byte_last  = (byte_q == (unit4 ? 2'd3 : 2'd1));
	assign st.run_last   = (remain_q == 5'd1);
	assign st.out_free   = out_free;

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.out_lit || ctl.out_err || ctl.out_cpy) |-> out_free)
		else $error("result loaded over an untaken one");
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.restart |=> (wp_q == '0) && !full_q)
		else $error("restart did not clear write position");
	a_err_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (m_tdata[34:32] == 3'd0) && m_tlast)
		else $error("error result with data bytes");
	a_copy_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.copy_first |-> (remain_q != 5'd0))
		else $error("copy started with no units left");

endmodule
`default_nettype wire

>>> rtl/texture_token_lz_decoder_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Literal (2-byte or 4-byte unit): decoded, looked up, bytes written to history in turn, then result registered.
// Back-reference: each unit is read, copied byte by byte into the history and registered;
// a short distance gives an error result with no data bytes.
// One request in flight, next taken the cycle after the last result is registered.
// arst_n clears format to raw and empties the history (fill marker, no sweep).
// ----------------------------------------------------------------------------
// texture_token_lz_decoder_top
// Expands 16-bit tokens into texture bytes with history back-references.
// ----------------------------------------------------------------------------
module texture_token_lz_decoder_top #(
	parameter int HISTORY_BYTES = 2048
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,   // token, table_index, table_value
	input  wire logic [1:0]  s_tuser,   // cmd
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_data,  // format_mode
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,   // out_data, out_bytes
	output logic             m_tlast,   // run_last
	output logic [0:0]       m_tuser    // bad_distance
);

	tlzd_pkg::ctl_t  ctl;
	tlzd_pkg::stat_t st;

	assign cfg_ready = 1'b1;

	tlzd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.st       (st),
		.ctl      (ctl)
	);

	tlzd_dp #(
		.HISTORY_BYTES (HISTORY_BYTES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.st        (st),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

endmodule
`default_nettype wire

>>> tb/texture_token_lz_decoder_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// texture_token_lz_decoder_checker
// Watches the request, result and format channels of the token decoder. It
// keeps its own copy of the history, lookup table and format. From each
// accepted request it works out the units due and checks them in order.
// ----------------------------------------------------------------------------
module texture_token_lz_decoder_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [47:0] s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_data,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [39:0] m_tdata,
	input  logic        m_tlast,
	input  logic [0:0]  m_tuser,
	output int          pending,
	output int          errors
);

	typedef struct packed {
		logic [31:0] data;
		logic [2:0]  nbytes;
		logic        last;
		logic        bad;
	} unit_t;

	unit_t       due_units[$];
	logic [2:0]  fmt = tlzd_pkg::MODE_RAW;
	logic [7:0]  hist[2048];
	logic [10:0] wr_pos = '0;
	logic [15:0] lut[tlzd_pkg::TABLE_ENTRIES];

	initial begin
		errors  = 0;
		pending = 0;
		foreach (hist[i]) hist[i] = 8'h00;
	end

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
		errors++;
	endtask

	function automatic void push_unit(logic [31:0] d, logic [2:0] n, logic l, logic b);
		unit_t u;
		u.data = d; u.nbytes = n; u.last = l; u.bad = b;
		due_units.push_back(u);
	endfunction

	function automatic void keep_bytes(logic [31:0] d, int n);
		for (int i = n - 1; i >= 0; i--) begin
			hist[wr_pos] = d[8*i +: 8];
			wr_pos = wr_pos + 11'd1;
		end
	endfunction

	function automatic logic [7:0] six_bit(logic [7:0] b);
		return {b[5:3], 1'b0, b[2:0], 1'b0};
	endfunction

	function automatic void expand_token(logic [1:0] cmd, logic [47:0] req);
		logic [15:0] t;
		logic [7:0]  hi, lo;
		logic [15:0] e0, e1;
		logic [31:0] d;
		logic [10:0] back_dist;
		int          nb, cnt;
		t  = req[15:0];
		hi = t[15:8];
		lo = t[7:0];
		if (cmd == tlzd_pkg::CMD_TABLE) begin
			lut[req[26:16]] = req[42:27];
			return;
		end
		if (cmd == tlzd_pkg::CMD_RESTART) begin
			foreach (hist[i]) hist[i] = 8'h00;
			wr_pos = '0;
			return;
		end
		if (cmd != tlzd_pkg::CMD_DECODE) return;
		if (fmt == tlzd_pkg::MODE_RAW || fmt == tlzd_pkg::MODE_RAW_ALT) begin
			keep_bytes({16'h0, t}, 2);
			push_unit({16'h0, t}, 3'd2, 1'b1, 1'b0);
			return;
		end
		nb = (fmt == tlzd_pkg::MODE_RGBA32 || fmt == tlzd_pkg::MODE_IA16_TBL ||
		      fmt == tlzd_pkg::MODE_RGBA_TBL) ? 4 : 2;
		if (!t[15]) begin
			case (fmt)
				tlzd_pkg::MODE_RGBA16: d = {15'h0, t[15:6], 1'b0, t[5:0]};
				tlzd_pkg::MODE_RGBA32:
					d = {t[14:11], 4'h0, t[10:7], 4'h0, t[6:3], 4'h0, t[2:0], 5'h0};
				tlzd_pkg::MODE_IA8:    d = {16'h0, hi[6:0], 1'b0, lo[6:0], 1'b0};
				tlzd_pkg::MODE_IA16_TBL: begin
					e0 = lut[{4'h0, hi[7:1]}];
					e1 = lut[{4'h0, lo[7:1]}];
					d  = {e0[14:0], hi[0], e1[14:0], lo[0]};
				end
				tlzd_pkg::MODE_RGBA_TBL: begin
					e0 = lut[t[14:4]];
					d  = {e0[14:10], 3'h0, e0[9:5], 3'h0, e0[4:0], 3'h0, t[3:0], 4'h0};
				end
				default:     d = {16'h0, six_bit(hi), six_bit(lo)};
			endcase
			keep_bytes(d, nb);
			push_unit(d, nb[2:0], 1'b1, 1'b0);
			return;
		end
		cnt  = t[4:0];
		back_dist = (nb == 4) ? {t[14:5], 1'b0} : {1'b0, t[14:5]};
		if (back_dist < nb) begin
			push_unit('0, 3'd0, 1'b1, 1'b1);
			return;
		end
		// copies go byte by byte so an overlapping run repeats itself
		for (int k = 0; k < cnt; k++) begin
			d = '0;
			for (int b = 0; b < nb; b++) begin
				d = {d[23:0], hist[wr_pos - back_dist]};
				hist[wr_pos] = d[7:0];
				wr_pos = wr_pos + 11'd1;
			end
			push_unit(d, nb[2:0], k + 1 == cnt, 1'b0);
		end
	endfunction

	always @(posedge clk) begin
		unit_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) fmt = cfg_data;
			if (s_tvalid && s_tready) expand_token(s_tuser, s_tdata);
			if (m_tvalid && m_tready) begin
				if (due_units.size() == 0) begin
					$display("%0t ns: unexpected result %0h", $time, m_tdata);
					errors++;
				end else begin
					want = due_units.pop_front();
					if (m_tdata[31:0] !== want.data) report("out_data", m_tdata[31:0], want.data);
					if (m_tdata[34:32] !== want.nbytes)
						report("out_bytes", m_tdata[34:32], want.nbytes);
					if (m_tdata[39:35] !== 5'h0) report("tdata pad", m_tdata[39:35], 0);
					if (m_tlast !== want.last) report("run_last", m_tlast, want.last);
					if (m_tuser[0] !== want.bad) report("bad_distance", m_tuser[0], want.bad);
				end
			end
		end
		pending <= due_units.size();
	end

endmodule

>>> tb/tb_texture_token_lz_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_texture_token_lz_decoder_top
// Drives token, table and restart requests through every format with random
// idling on both sides; the checker predicts and compares the decoded units.
// ----------------------------------------------------------------------------
module tb_texture_token_lz_decoder_top;

	localparam int CYCLE_LIMIT = 1000000;
	// table entries reachable from the literals sent
	localparam int TABLE_FILL  = 128;
	localparam logic [1:0] CMD_SPARE = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;
	logic [1:0]  s_tuser = tlzd_pkg::CMD_DECODE;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_data = tlzd_pkg::MODE_RAW;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic        m_tlast;
	logic [0:0]  m_tuser;
	int          pending, errors;
	int          cycles = 0;
	int          send_idle = 0, recv_stall = 0;
	int          hold_cycles = 0;
	logic [2:0]  cur_fmt = tlzd_pkg::MODE_RAW;

	always #5 clk = ~clk;

	texture_token_lz_decoder_top uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tlast(m_tlast), .m_tuser(m_tuser)
	);

	texture_token_lz_decoder_checker chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tlast(m_tlast), .m_tuser(m_tuser),
		.pending(pending), .errors(errors)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_texture_token_lz_decoder_top failed");
			$finish;
		end
	end

	// receiver: random stalls, or a long hold-off while hold_cycles runs down
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= recv_stall);
		end
	end

	task automatic send_request(input logic [1:0] cmd, input logic [15:0] tok,
			input logic [10:0] idx, input logic [15:0] val);
		if ($urandom_range(0, 99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(0, 99) < send_idle) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {5'h0, val, idx, tok};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic decode(input logic [15:0] tok);
		logic [15:0] t;
		t = tok;
		// RGBA table literals index with t[14:4]; keep them inside the filled entries
		if (cur_fmt == tlzd_pkg::MODE_RGBA_TBL && !t[15]) t[14:11] = 4'h0;
		send_request(tlzd_pkg::CMD_DECODE, t, 11'($urandom), 16'($urandom));
	endtask

	// back-reference with distance field d and run length n
	function automatic logic [15:0] back_ref(int d, int n);
		return {1'b1, 10'(d), 5'(n)};
	endfunction

	task automatic drain_and_set(input logic [2:0] fmt);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		// a zero-length run may still be busy with no result owed
		repeat (40) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= fmt;
		cur_fmt    = fmt;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_request();
		int pick, d;
		pick = $urandom_range(0, 99);
		if (pick < 3)
			send_request(tlzd_pkg::CMD_RESTART, 16'($urandom), 11'($urandom), 16'($urandom));
		else if (pick < 6)
			send_request(CMD_SPARE, 16'($urandom), 11'($urandom), 16'($urandom));
		else if (pick < 10)
			send_request(tlzd_pkg::CMD_TABLE, 16'($urandom), 11'($urandom), 16'($urandom));
		else if (pick < 50) decode({1'b0, 15'($urandom)});
		else if (pick < 58) decode(16'($urandom));
		else begin
			pick = $urandom_range(0, 99);
			if (pick < 8) d = $urandom_range(0, 1);
			else if (pick < 25) d = $urandom_range(0, 1023);
			else d = $urandom_range(2, 40);
			decode(back_ref(d, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
				: $urandom_range(0, 6)));
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill every table entry that a literal can look up
		for (int i = 0; i < TABLE_FILL; i++)
			send_request(tlzd_pkg::CMD_TABLE, 16'($urandom), 11'(i), 16'($urandom));

		for (int m = 0; m < 8; m++) begin
			drain_and_set(3'(m));
			case (m % 4)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 62; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 62; end
				default: begin send_idle = 35; recv_stall = 35; end
			endcase
			send_request(tlzd_pkg::CMD_RESTART, 16'h0, 11'h0, 16'h0);
			decode(16'h0000);
			decode(16'h7FFF);
			decode(16'hFFFF);
			decode(back_ref(1, 31));      // distance below one unit
			decode(back_ref(2, 0));       // empty run
			decode(back_ref(2, 31));      // overlapping copy
			decode(back_ref(1000, 3));    // reaches past the start of the block
			send_request(CMD_SPARE, 16'hFFFF, 11'h7FF, 16'hFFFF);
			if (m == 2) hold_cycles = 400;
			for (int i = 0; i < 20; i++) random_request();
		end

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("tb_texture_token_lz_decoder_top passed");
		else
			$display("tb_texture_token_lz_decoder_top failed");
		$finish;
	end

endmodule
